FILE: src/skle_pkg.sv
package skle_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] found_value;
    logic [4:0]         entry_count;
  } rsp_t;

  // broadcast to every cell
  typedef struct packed {
    logic               insert_en;
    logic               remove_en;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } cmd_t;

  // match result rippling down the chain
  typedef struct packed {
    logic               hit;
    logic signed [31:0] value;
  } acc_t;

  typedef struct packed {
    logic load;
    logic commit;
  } ctrl_t;

endpackage

FILE: src/sorted_key_list_engine.sv
// sorted key/value store: a row of cells, one entry per cell, kept in ascending key order
// the response word is registered at commit, after the match result has rippled down the row
// a new request word is taken only after the previous one commits, as it waits for the match result rippling
//   one cell per cycle down the row before the update is committed
// reset (rst, synchronous, active high) empties the store and drops any pending response
module sorted_key_list_engine
  import skle_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int COUNT_W = $clog2(CAPACITY + 1);

  ctrl_t ctl;

  // request held for the whole scan
  logic [1:0]         op_q;
  logic signed [31:0] key_q;
  logic signed [31:0] value_q;

  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic               full;
  logic               hit;
  cmd_t               cmd;
  rsp_t               rsp_next;

  logic signed [31:0] cell_key   [CAPACITY];
  logic signed [31:0] cell_value [CAPACITY];
  logic               cell_le    [CAPACITY];
  logic               cell_occ   [CAPACITY];
  acc_t               cell_acc   [CAPACITY];

  skle_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .rsp_stall (rsp_stall),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .ctl       (ctl)
  );

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_q    <= req.operation;
      key_q   <= req.key;
      value_q <= req.value;
    end
  end

  assign full = (count == COUNT_W'(CAPACITY));
  // last cell's result is the first match over the whole row
  assign hit  = cell_acc[CAPACITY-1].hit;

  assign cmd.insert_en = ctl.commit & (op_q == OP_INSERT) & ~full;
  assign cmd.remove_en = ctl.commit & (op_q == OP_REMOVE) & hit;
  assign cmd.key       = key_q;
  assign cmd.value     = value_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    // cell i holds a live entry when it sits below the fill count
    assign cell_occ[i] = (COUNT_W'(i) < count);

    if (i == 0) begin : g_head
      skle_cell u_cell (
        .clk         (clk),
        .cmd         (cmd),
        .occ         (cell_occ[i]),
        .left_key    ('0),
        .left_value  ('0),
        .left_le     (1'b1),
        .left_occ    (1'b0),
        .right_key   (cell_key[i+1]),
        .right_value (cell_value[i+1]),
        .acc_in      ('0),
        .slot_key    (cell_key[i]),
        .slot_value  (cell_value[i]),
        .le          (cell_le[i]),
        .acc_out     (cell_acc[i])
      );
    end else if (i == CAPACITY - 1) begin : g_tail
      skle_cell u_cell (
        .clk         (clk),
        .cmd         (cmd),
        .occ         (cell_occ[i]),
        .left_key    (cell_key[i-1]),
        .left_value  (cell_value[i-1]),
        .left_le     (cell_le[i-1]),
        .left_occ    (cell_occ[i-1]),
        .right_key   ('0),
        .right_value ('0),
        .acc_in      (cell_acc[i-1]),
        .slot_key    (cell_key[i]),
        .slot_value  (cell_value[i]),
        .le          (cell_le[i]),
        .acc_out     (cell_acc[i])
      );
    end else begin : g_mid
      skle_cell u_cell (
        .clk         (clk),
        .cmd         (cmd),
        .occ         (cell_occ[i]),
        .left_key    (cell_key[i-1]),
        .left_value  (cell_value[i-1]),
        .left_le     (cell_le[i-1]),
        .left_occ    (cell_occ[i-1]),
        .right_key   (cell_key[i+1]),
        .right_value (cell_value[i+1]),
        .acc_in      (cell_acc[i-1]),
        .slot_key    (cell_key[i]),
        .slot_value  (cell_value[i]),
        .le          (cell_le[i]),
        .acc_out     (cell_acc[i])
      );
    end
  end

  // fill count and response word, both settled at commit
  always_comb begin
    count_next           = count;
    rsp_next.status      = ST_DONE;
    rsp_next.found_value = '0;
    unique case (op_q)
      OP_INSERT: begin
        if (full) begin
          rsp_next.status = ST_FULL;
        end else begin
          count_next = COUNT_W'(count + 1'b1);
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          count_next = COUNT_W'(count - 1'b1);
        end else begin
          rsp_next.status = ST_MISSING;
        end
      end
      OP_FIND: begin
        if (hit) begin
          rsp_next.found_value = cell_acc[CAPACITY-1].value;
        end else begin
          rsp_next.status = ST_MISSING;
        end
      end
      default: begin
        // unused code: store untouched, plain done
        rsp_next.status = ST_DONE;
      end
    endcase
    rsp_next.entry_count = 5'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.commit) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      rsp <= rsp_next;
    end
  end

endmodule

FILE: src/skle_cell.sv
module skle_cell
  import skle_pkg::*;
(
  input  logic               clk,
  input  cmd_t               cmd,
  input  logic               occ,
  input  logic signed [31:0] left_key,
  input  logic signed [31:0] left_value,
  input  logic               left_le,
  input  logic               left_occ,
  input  logic signed [31:0] right_key,
  input  logic signed [31:0] right_value,
  input  acc_t               acc_in,
  output logic signed [31:0] slot_key,
  output logic signed [31:0] slot_value,
  output logic               le,
  output acc_t               acc_out
);

  logic signed [31:0] slot_key_next;
  logic signed [31:0] slot_value_next;
  logic               ge;
  logic               take_new;
  logic               shift_in;
  acc_t               acc_next;

  assign le       = occ & (slot_key <= cmd.key);
  assign ge       = occ & (slot_key >= cmd.key);
  // list is sorted, so the boundary is where le flips
  assign take_new = left_le & ~le;
  assign shift_in = left_occ & ~left_le;

  always_comb begin
    slot_key_next   = slot_key;
    slot_value_next = slot_value;
    if (cmd.insert_en) begin
      if (take_new) begin
        slot_key_next   = cmd.key;
        slot_value_next = cmd.value;
      end else if (shift_in) begin
        slot_key_next   = left_key;
        slot_value_next = left_value;
      end
    end else if (cmd.remove_en && ge) begin
      slot_key_next   = right_key;
      slot_value_next = right_value;
    end
  end

  // first match upstream wins
  always_comb begin
    if (acc_in.hit) begin
      acc_next = acc_in;
    end else if (occ && (slot_key == cmd.key)) begin
      acc_next.hit   = 1'b1;
      acc_next.value = slot_value;
    end else begin
      acc_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    slot_key   <= slot_key_next;
    slot_value <= slot_value_next;
    acc_out    <= acc_next;
  end

endmodule

FILE: src/skle_ctrl.sv
module skle_ctrl
  import skle_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  input  logic  rsp_stall,
  output logic  req_stall,
  output logic  rsp_valid,
  output ctrl_t ctl
);

  localparam int CNT_W = $clog2(CAPACITY);

  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   cnt_next;

  // no word taken while held in reset
  assign req_stall = rst | (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          ctl.load   = 1'b1;
          cnt_next   = '0;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cnt_next = CNT_W'(cnt + 1'b1);
        if (cnt == CNT_W'(CAPACITY - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          ctl.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

FILE: src/skle_checker.sv
module skle_checker
  import skle_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // reset drops any pending response
  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid right after reset");

  // a stalled response word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response word changed");

  // one request at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while previous one in flight");

  // a value comes back only with status done
  a_value_only_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_DONE) |-> rsp.found_value == '0)
    else $error("nonzero found value on failed request");

endmodule

bind sorted_key_list_engine skle_checker u_skle_checker (.*);
